// ===== src/dtq_pkg.sv =====
// Shared types, codes and constants of the deadline timer queue.
package dtq_pkg;

  localparam int unsigned DefDepth   = 16;
  localparam logic [15:0] RetryReset = 16'd100;
  localparam logic [47:0] Max48      = 48'hFFFF_FFFF_FFFF;

  // Command codes on the request port.
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // Result kinds and status codes.
  localparam logic [1:0] KIND_FIRED = 2'd0;
  localparam logic [1:0] KIND_REARM = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic [1:0] KIND_ACK   = 2'd3;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOTFND  = 2'd2;

  typedef enum logic [1:0] {OP_ADD, OP_CANCEL, OP_TICK, OP_NOP} op_e;

  typedef enum logic [2:0] {T_NONE, T_INSERT, T_POP, T_REMOVE, T_CLRTAG} tbl_op_e;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_CANCEL, S_TICK, S_TICK_INS, S_REARM, S_ACK
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  id;
    logic [47:0] dl;
    logic [31:0] per;
    logic        rep;
    logic [47:0] now;
  } item_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [47:0] dl;
    logic [31:0] per;
    logic        rep;
    logic        tag;
  } ent_t;

  typedef struct packed {
    tbl_op_e op;
    ent_t    ent;
  } tbl_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [7:0]  id;
    logic [47:0] dl;
    logic [47:0] delay;
    logic        last;
  } res_t;

endpackage

// ===== src/deadline_timer_queue_unit.sv =====
// Top level of the deadline timer queue.
// Requests are taken when start is high and busy is low; a two-entry queue lets a
// new request in while earlier ones are still being carried out. Each result
// appears for one cycle with result_valid_o and cannot be held off. A tick
// fires due entries one by one and re-inserts each periodic one; the sorted
// register table takes a single table update per cycle.
module deadline_timer_queue_unit
  import dtq_pkg::*;
#(
  parameter int unsigned TableDepth = DefDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  event_id_i,
  input  logic [47:0] deadline_ms_i,
  input  logic [31:0] period_ms_i,
  input  logic        periodic_i,
  input  logic [47:0] now_ms_i,
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic [1:0]  status_o,
  output logic [7:0]  fired_id_o,
  output logic [47:0] fired_deadline_o,
  output logic [47:0] rearm_delay_ms_o,
  output logic        last_o
);

  logic        retry_we;
  logic [15:0] retry_q;
  logic        avail, pop, empty, full, found;
  item_t       item;
  tbl_req_t    treq;
  ent_t        head;
  res_t        res;

  // Retry delay register.
  assign retry_we = cfg_we_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q <= RetryReset;
    end else if (retry_we) begin
      retry_q <= cfg_wdata_i;
    end
  end

  dtq_front u_front (
    .clk_i, .rst_ni,
    .push_i (start && !busy),
    .cmd_i, .event_id_i, .deadline_ms_i, .period_ms_i, .periodic_i, .now_ms_i,
    .pop_i (pop), .full_o (busy), .avail_o (avail), .item_o (item)
  );

  dtq_back u_back (
    .clk_i, .rst_ni,
    .avail_i (avail), .item_i (item), .pop_o (pop), .retry_i (retry_q),
    .tbl_o (treq), .head_i (head), .empty_i (empty), .full_i (full),
    .found_i (found), .res_valid_o (result_valid_o), .res_o (res)
  );

  dtq_table #(.Depth(TableDepth)) u_table (
    .clk_i, .rst_ni,
    .req_i (treq), .head_o (head), .empty_o (empty), .full_o (full), .found_o (found)
  );

  assign kind_o           = res.kind;
  assign status_o         = res.status;
  assign fired_id_o       = res.id;
  assign fired_deadline_o = res.dl;
  assign rearm_delay_ms_o = res.delay;
  assign last_o           = res.last;

endmodule

// ===== src/dtq_front.sv =====
// Front end: classifies requests and holds them in a two-entry queue.
module dtq_front
  import dtq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  event_id_i,
  input  logic [47:0] deadline_ms_i,
  input  logic [31:0] period_ms_i,
  input  logic        periodic_i,
  input  logic [47:0] now_ms_i,
  input  logic        pop_i,
  output logic        full_o,
  output logic        avail_o,
  output item_t       item_o
);

  item_t      slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  item_t      in_item;

  // Classify the command code.
  always_comb begin
    in_item     = '0;
    in_item.id  = event_id_i;
    in_item.dl  = deadline_ms_i;
    in_item.per = period_ms_i;
    in_item.rep = periodic_i;
    in_item.now = now_ms_i;
    unique case (cmd_i)
      CMD_ADD:    in_item.op = OP_ADD;
      CMD_CANCEL: in_item.op = OP_CANCEL;
      CMD_TICK:   in_item.op = OP_TICK;
      default:    in_item.op = OP_NOP;
    endcase
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= in_item;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign full_o  = cnt_q[1];
  assign avail_o = (cnt_q != 2'd0);
  assign item_o  = slot_q[rp_q];

endmodule

// ===== src/dtq_table.sv =====
// Sorted timer table in registers, with one insert, pop, removal or tag clear per cycle.
module dtq_table
  import dtq_pkg::*;
#(
  parameter int unsigned Depth = DefDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tbl_req_t req_i,
  output ent_t     head_o,
  output logic     empty_o,
  output logic     full_o,
  output logic     found_o
);

  localparam int unsigned CW = $clog2(Depth + 1);

  ent_t          ent_q [Depth];
  ent_t          ent_d [Depth];
  logic [CW-1:0] cnt_q, cnt_d;
  logic [Depth-1:0] live, le, match, hit;

  // Per-slot compare results and mask of the slots at and after the first match.
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      live[i]  = (CW'(i) < cnt_q);
      le[i]    = live[i] && (ent_q[i].dl <= req_i.ent.dl);
      match[i] = live[i] && (ent_q[i].id == req_i.ent.id);
      seen     = seen | match[i];
      hit[i]   = seen;
    end
  end

  // Next contents of every slot.
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < Depth; i++) begin
      ent_d[i] = ent_q[i];
      unique case (req_i.op)
        T_INSERT: begin
          if (!le[i]) begin
            if (i == 0) ent_d[i] = req_i.ent;
            else if (le[(i == 0) ? 0 : i - 1]) ent_d[i] = req_i.ent;
            else ent_d[i] = ent_q[(i == 0) ? 0 : i - 1];
          end
        end
        T_POP: begin
          if (i + 1 < Depth) ent_d[i] = ent_q[(i + 1 < Depth) ? i + 1 : i];
        end
        T_REMOVE: begin
          if (hit[i] && (i + 1 < Depth)) ent_d[i] = ent_q[(i + 1 < Depth) ? i + 1 : i];
        end
        T_CLRTAG: ent_d[i].tag = 1'b0;
        default: ;
      endcase
    end
    unique case (req_i.op)
      T_INSERT: cnt_d = cnt_q + CW'(1);
      T_POP:    cnt_d = cnt_q - CW'(1);
      T_REMOVE: if (|match) cnt_d = cnt_q - CW'(1);
      default: ;
    endcase
  end

  // Entry payload.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) ent_q[i] <= ent_d[i];
  end

  // Fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = ent_q[0];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(Depth));
  assign found_o = |match;

endmodule

// ===== src/dtq_back.sv =====
// Back end: sequencer that carries out one request and produces its results.
module dtq_back
  import dtq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        avail_i,
  input  item_t       item_i,
  output logic        pop_o,
  input  logic [15:0] retry_i,
  output tbl_req_t    tbl_o,
  input  ent_t        head_i,
  input  logic        empty_i,
  input  logic        full_i,
  input  logic        found_i,
  output logic        res_valid_o,
  output res_t        res_o
);

  state_e      state_q, state_d;
  item_t       cur_q, cur_d;
  ent_t        fire_q, fire_d;
  logic        rv_q, rv_d;
  res_t        res_q, res_d;
  logic [48:0] sum;

  // Re-insertion deadline, saturated to 48 bits.
  assign sum = {1'b0, cur_q.now} + {17'd0, head_i.per};

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    fire_d  = fire_q;
    rv_d    = 1'b0;
    res_d   = '0;
    pop_o   = 1'b0;
    tbl_o   = '0;
    tbl_o.op = T_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (avail_i) begin
          pop_o = 1'b1;
          cur_d = item_i;
          unique case (item_i.op)
            OP_ADD:    state_d = S_ADD;
            OP_CANCEL: state_d = S_CANCEL;
            OP_TICK:   state_d = S_TICK;
            default:   state_d = S_ACK;
          endcase
        end
      end
      S_ADD: begin
        if (full_i) begin
          rv_d = 1'b1;
          res_d.kind = KIND_ACK;
          res_d.status = ST_FULL;
          res_d.last = 1'b1;
          state_d = S_IDLE;
        end else begin
          tbl_o.op = T_INSERT;
          tbl_o.ent = '{id: cur_q.id, dl: cur_q.dl, per: cur_q.per, rep: cur_q.rep,
                        tag: 1'b0};
          if (empty_i || (head_i.dl > cur_q.dl)) begin
            state_d = S_REARM;
          end else begin
            rv_d = 1'b1;
            res_d.kind = KIND_ACK;
            res_d.last = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_CANCEL: begin
        tbl_o.op = T_REMOVE;
        tbl_o.ent.id = cur_q.id;
        rv_d = 1'b1;
        res_d.kind = KIND_ACK;
        res_d.status = found_i ? ST_OK : ST_NOTFND;
        res_d.last = 1'b1;
        state_d = S_IDLE;
      end
      S_TICK: begin
        if (!empty_i && !head_i.tag && (head_i.dl <= cur_q.now)) begin
          rv_d = 1'b1;
          res_d.kind = KIND_FIRED;
          res_d.id = head_i.id;
          res_d.dl = head_i.dl;
          tbl_o.op = T_POP;
          fire_d = head_i;
          fire_d.dl = sum[48] ? Max48 : sum[47:0];
          fire_d.tag = 1'b1;
          if (head_i.rep) state_d = S_TICK_INS;
        end else begin
          tbl_o.op = T_CLRTAG;
          state_d = S_REARM;
        end
      end
      S_TICK_INS: begin
        tbl_o.op = T_INSERT;
        tbl_o.ent = fire_q;
        state_d = S_TICK;
      end
      S_REARM: begin
        rv_d = 1'b1;
        res_d.last = 1'b1;
        if (empty_i) begin
          res_d.kind = KIND_EMPTY;
        end else begin
          res_d.kind = KIND_REARM;
          res_d.delay = (head_i.dl > cur_q.now) ? (head_i.dl - cur_q.now)
                                                : {32'd0, retry_i};
        end
        state_d = S_IDLE;
      end
      S_ACK: begin
        rv_d = 1'b1;
        res_d.kind = KIND_ACK;
        res_d.last = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= rv_d;
    end
  end

  // Working item and result payload.
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    fire_q <= fire_d;
    res_q  <= res_d;
  end

  assign res_valid_o = rv_q;
  assign res_o       = res_q;

endmodule

// ===== src/dtq_checker.sv =====
// Port-level checks of the deadline timer queue, bound to the top level.
module dtq_checker
  import dtq_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        result_valid_o,
  input logic [1:0]  kind_o,
  input logic [1:0]  status_o,
  input logic        last_o
);

  // A fired entry is never the final result of a request.
  a_fired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o == KIND_FIRED) |-> !last_o) else $error("fired with last");

  // Every other kind closes its request.
  a_other_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o != KIND_FIRED) |-> last_o) else $error("missing last");

  // Only acknowledges carry a non-ok status.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != ST_OK) |-> (kind_o == KIND_ACK))
    else $error("status on wrong kind");

  // A result closing a request is not followed at once by another result.
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o) else $error("result too soon");

endmodule

bind deadline_timer_queue_unit dtq_checker u_dtq_checker (
  .clk_i, .rst_ni, .result_valid_o, .kind_o, .status_o, .last_o
);
